### sv/tlbr_pkg.sv
// Shared types and field layout for the TLB refill block.
package tlbr_pkg;

    typedef enum logic [0:0] {
        OP_REFILL = 1'b0,
        OP_MARK   = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_REFILL   = 3'd0,
        ST_FAULT    = 3'd1,
        ST_ADDR_ERR = 3'd2,
        ST_DIRTY    = 3'd3,
        ST_NO_MATCH = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEC,
        S_RDW,
        S_SLOT,
        S_WR,
        S_MARK,
        S_FIN
    } t_state;

    // Request and result field widths.
    localparam int VADDR_W   = 32;
    localparam int PROC_W    = 8;
    localparam int SPACE_W   = 26;
    localparam int TICK_W    = 32;
    localparam int FNO_W     = 5;
    localparam int SLOT_W    = 2;
    localparam int VPAGE_W   = 25;
    localparam int CNT_W     = 32;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 144;

endpackage

### sv/tlb_refill_with_lru_frames.sv
// Top level: TLB miss handler with an inverted frame table and LRU frame choice.
//
// Requests enter on the s_axis channel: tuser carries the opcode (refill or
// mark dirty), tdata the address, process id, address-space size, mapped flag
// and time stamp. Each request gives exactly one result on m_axis: tuser is
// the status, tdata the frame, TLB slot, victim description and the three
// running counters.
// A refill walks the frame table memory once, one entry per cycle, then
// reads the chosen frame back, picks and loads a TLB slot and writes the
// frame entry; an address error ends once the scan is decided. A
// mark-dirty request searches the TLB registers combinationally.
// The frame-table read port is the limit: one request is in work at a time
// and the next is accepted when the block is back to idle.
// The result sits in an output register; while the receiver stalls it holds,
// and a finished request waits in its last state until the register is free.
// Reset (synchronous, active low) invalidates all frames and TLB entries and
// clears the FIFO pointer and counters; no memory clearing pass is needed.
module tlb_refill_with_lru_frames
    import tlbr_pkg::*;
#(
    parameter int FRAMES      = 32,
    parameter int TLB_ENTRIES = 4,
    parameter int PAGE_BITS   = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // vaddr[31:0], proc_id[39:32], space_pages[65:40], in_mapped_region[66],
    // now_tick[98:67], zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // opcode[0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // frame_no[4:0], tlb_slot[6:5], victim_valid[7], wrote_back[8],
    // victim_page[33:9], victim_proc[41:34], miss_count[73:42],
    // fault_count[105:74], writeback_count[137:106], zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]            o_m_axis_tuser
);

    localparam int AW = $clog2(FRAMES);
    localparam int SW = $clog2(TLB_ENTRIES);
    localparam int PW = VADDR_W - PAGE_BITS;
    localparam int WW = PROC_W + PW + TICK_W + SW;

    t_state r_state, n_state;

    // Captured request
    logic [PW-1:0]        r_page;
    logic [PROC_W-1:0]    r_pid;
    logic [SPACE_W-1:0]   r_space;
    logic                 r_mapped;
    logic [TICK_W-1:0]    r_now;

    // Frame flags kept in flops
    logic [FRAMES-1:0]    r_fvalid;
    logic [FRAMES-1:0]    r_fin_tlb;

    // TLB
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [PW-1:0]          r_tlb_page  [TLB_ENTRIES];
    logic [AW-1:0]          r_tlb_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_dirty;
    logic [SW-1:0]          r_fifo;

    logic [CNT_W-1:0]     r_misses, r_faults, r_wbacks;

    // Scan state
    logic [AW:0]          r_cnt;
    logic                 r_sv;
    logic [AW-1:0]        r_didx;
    logic                 r_hit, r_free;
    logic [AW-1:0]        r_hf, r_fidx, r_bidx;
    logic [TICK_W-1:0]    r_best;

    // Working frame
    logic [AW-1:0]        r_f;
    logic                 r_is_fault;
    logic                 r_fdirty;

    // Result
    t_status              r_status;
    logic [AW-1:0]        r_fno;
    logic [SW-1:0]        r_slot;
    logic                 r_vv, r_wb;
    logic [PW-1:0]        r_vpage;
    logic [PROC_W-1:0]    r_vproc;

    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic [2:0]            r_ouser;

    // Memory ports
    logic [AW-1:0] m_raddr, m_waddr, d_waddr;
    logic [WW-1:0] m_rdata, m_wdata;
    logic          m_we, d_we, d_wdata, d_rdata;

    logic [PROC_W-1:0] w_proc;
    logic [PW-1:0]     w_page;
    logic [TICK_W-1:0] w_lu;
    logic [SW-1:0]     w_slot;

    logic          in_acc, out_load;
    logic [AW-1:0] dec_f;
    logic          addr_err;

    logic          free_found;
    logic [SW-1:0] s_free, s_sel, s_next;
    logic          fifo_upd;
    logic          evict;
    logic [AW-1:0] evict_g;

    logic          mk_found;
    logic [SW-1:0] mk_slot;

    logic          vic_in_tlb;

    assign {w_proc, w_page, w_lu, w_slot} = m_rdata;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = !r_ovalid || i_m_axis_tready;
    assign dec_f    = r_hit ? r_hf : (r_free ? r_fidx : r_bidx);
    assign addr_err = !r_hit && (32'(r_page) >= 32'(r_space)) && !r_mapped;
    assign vic_in_tlb = r_fin_tlb[r_f] && (32'(w_slot) < TLB_ENTRIES);

    // First invalid TLB slot, else the FIFO pointer
    always_comb begin
        free_found = 1'b0;
        s_free     = '0;
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            if (!r_tlb_valid[j] && !free_found) begin
                free_found = 1'b1;
                s_free     = SW'(j);
            end
        end
        s_sel    = free_found ? s_free : r_fifo;
        fifo_upd = !free_found || (s_sel == r_fifo);
        s_next   = (32'(s_sel) == TLB_ENTRIES - 1) ? '0 : s_sel + SW'(1);
        evict    = r_tlb_valid[s_sel] && (32'(r_tlb_frame[s_sel]) < FRAMES);
        evict_g  = r_tlb_frame[s_sel];
    end

    // First valid TLB entry with a matching page
    always_comb begin
        mk_found = 1'b0;
        mk_slot  = '0;
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            if (r_tlb_valid[j] && r_tlb_page[j] == r_page && !mk_found) begin
                mk_found = 1'b1;
                mk_slot  = SW'(j);
            end
        end
    end

    // Memory port control
    always_comb begin
        m_raddr = (r_state == S_SCAN) ? r_cnt[AW-1:0] : dec_f;
        m_we    = (r_state == S_WR);
        m_waddr = r_f;
        m_wdata = {r_pid, r_page, r_now, r_slot};
        d_we    = 1'b0;
        d_waddr = r_f;
        d_wdata = r_fdirty;
        if (r_state == S_SLOT && evict) begin
            d_we    = 1'b1;
            d_waddr = evict_g;
            d_wdata = r_tlb_dirty[s_sel];
        end else if (r_state == S_WR) begin
            d_we = 1'b1;
        end
    end

    tlbr_ram #(.WIDTH(WW), .DEPTH(FRAMES)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    tlbr_ram #(.WIDTH(1), .DEPTH(FRAMES)) u_dirty_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (m_raddr),
        .o_rdata (d_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = (t_opcode'(i_s_axis_tuser) == OP_MARK) ? S_MARK : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_sv && r_didx == AW'(FRAMES - 1)) begin
                    n_state = S_DEC;
                end
            end
            S_DEC:  n_state = addr_err ? S_FIN : S_RDW;
            S_RDW:  n_state = S_SLOT;
            S_SLOT: n_state = S_WR;
            S_WR:   n_state = S_FIN;
            S_MARK: n_state = S_FIN;
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fvalid    <= '0;
            r_fin_tlb   <= '0;
            r_tlb_valid <= '0;
            r_fifo      <= '0;
            r_misses    <= '0;
            r_faults    <= '0;
            r_wbacks    <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_RDW: begin
                    if (r_is_fault) begin
                        r_fvalid[r_f] <= 1'b1;
                        if (r_fvalid[r_f] && vic_in_tlb) begin
                            r_tlb_valid[w_slot] <= 1'b0;
                        end
                    end
                end
                S_SLOT: begin
                    if (fifo_upd) begin
                        r_fifo <= s_next;
                    end
                    if (evict) begin
                        r_fin_tlb[evict_g] <= 1'b0;
                    end
                    r_tlb_valid[s_sel] <= 1'b1;
                end
                S_WR: begin
                    r_fin_tlb[r_f] <= 1'b1;
                    r_misses <= r_misses + CNT_W'(1);
                    r_faults <= r_faults + CNT_W'(r_is_fault);
                    r_wbacks <= r_wbacks + CNT_W'(r_wb);
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_page   <= i_s_axis_tdata[VADDR_W-1:PAGE_BITS];
                    r_pid    <= i_s_axis_tdata[39:32];
                    r_space  <= i_s_axis_tdata[65:40];
                    r_mapped <= i_s_axis_tdata[66];
                    r_now    <= i_s_axis_tdata[98:67];
                    r_cnt    <= '0;
                    r_sv     <= 1'b0;
                    r_hit    <= 1'b0;
                    r_free   <= 1'b0;
                    r_vv     <= 1'b0;
                    r_wb     <= 1'b0;
                    r_vpage  <= '0;
                    r_vproc  <= '0;
                end
            end
            S_SCAN: begin
                if (32'(r_cnt) < FRAMES) begin
                    r_cnt <= r_cnt + (AW+1)'(1);
                end
                r_sv   <= (32'(r_cnt) < FRAMES);
                r_didx <= r_cnt[AW-1:0];
                if (r_sv) begin
                    if (r_fvalid[r_didx] && w_page == r_page && w_proc == r_pid && !r_hit) begin
                        r_hit <= 1'b1;
                        r_hf  <= r_didx;
                    end
                    if (!r_fvalid[r_didx] && !r_free) begin
                        r_free <= 1'b1;
                        r_fidx <= r_didx;
                    end
                    // Strict compare keeps ties on the lowest index
                    if (r_didx == '0 || w_lu < r_best) begin
                        r_best <= w_lu;
                        r_bidx <= r_didx;
                    end
                end
            end
            S_DEC: begin
                r_f        <= dec_f;
                r_is_fault <= !r_hit;
                if (addr_err) begin
                    r_status <= ST_ADDR_ERR;
                    r_fno    <= '0;
                    r_slot   <= '0;
                end
            end
            S_RDW: begin
                if (r_is_fault) begin
                    r_fdirty <= 1'b0;
                    if (r_fvalid[r_f]) begin
                        r_vv    <= 1'b1;
                        r_vpage <= w_page;
                        r_vproc <= w_proc;
                        r_wb    <= vic_in_tlb ? r_tlb_dirty[w_slot] : d_rdata;
                    end
                end else begin
                    r_fdirty <= d_rdata;
                end
            end
            S_SLOT: begin
                r_tlb_page[s_sel]  <= r_page;
                r_tlb_frame[s_sel] <= r_f;
                // An evicted entry for this same frame hands over its dirty bit
                if (evict && evict_g == r_f) begin
                    r_tlb_dirty[s_sel] <= r_tlb_dirty[s_sel];
                    r_fdirty           <= r_tlb_dirty[s_sel];
                end else begin
                    r_tlb_dirty[s_sel] <= r_fdirty;
                end
                r_slot <= s_sel;
            end
            S_WR: begin
                r_status <= r_is_fault ? ST_FAULT : ST_REFILL;
                r_fno    <= r_f;
            end
            S_MARK: begin
                if (mk_found) begin
                    r_tlb_dirty[mk_slot] <= 1'b1;
                    r_status <= ST_DIRTY;
                    r_fno    <= r_tlb_frame[mk_slot];
                    r_slot   <= mk_slot;
                end else begin
                    r_status <= ST_NO_MATCH;
                    r_fno    <= '0;
                    r_slot   <= '0;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    r_ouser <= r_status;
                    r_odata <= {6'd0, r_wbacks, r_faults, r_misses,
                                r_vproc, VPAGE_W'(r_vpage), r_wb, r_vv,
                                SLOT_W'(r_slot), FNO_W'(r_fno)};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    a_fifo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fifo) < TLB_ENTRIES)
        else $error("FIFO pointer out of range");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> 32'(r_cnt) <= FRAMES)
        else $error("frame scan ran past the table");

    a_err_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && r_status == ST_ADDR_ERR |-> !r_vv && !r_wb)
        else $error("address error reports a victim");

    a_wr_after_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> $past(r_state) == S_SLOT)
        else $error("frame write without slot selection");

endmodule

### sv/tlbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module tlbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### test/tlb_refill_with_lru_frames_check.sv
// Checker: watches both streams, predicts each result and compares it field by field.
module tlb_refill_with_lru_frames_check
    import tlbr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tuser,
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    input  logic [2:0]            i_m_axis_tuser,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFRAMES = 32;
    localparam int NSLOTS  = 4;
    localparam int PG_SHIFT = 7;

    typedef struct packed {
        t_status            status;
        logic [FNO_W-1:0]   frame_no;
        logic [SLOT_W-1:0]  slot;
        logic               victim_valid;
        logic               wrote_back;
        logic [VPAGE_W-1:0] victim_page;
        logic [PROC_W-1:0]  victim_proc;
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   faults;
        logic [CNT_W-1:0]   writebacks;
    } t_outcome;

    // frame table and TLB mirror
    logic               fr_valid  [NFRAMES];
    logic [PROC_W-1:0]  fr_proc   [NFRAMES];
    logic [VPAGE_W-1:0] fr_page   [NFRAMES];
    logic               fr_dirty  [NFRAMES];
    logic [TICK_W-1:0]  fr_used   [NFRAMES];
    logic               fr_in_tlb [NFRAMES];
    logic [SLOT_W-1:0]  fr_slot   [NFRAMES];
    logic               tl_valid  [NSLOTS];
    logic [VPAGE_W-1:0] tl_page   [NSLOTS];
    logic [FNO_W-1:0]   tl_frame  [NSLOTS];
    logic               tl_dirty  [NSLOTS];
    logic [SLOT_W-1:0]  fifo_ptr;
    logic [CNT_W-1:0]   n_miss, n_fault, n_wb;

    t_outcome outcome_q[$];

    assign o_pending = outcome_q.size();

    task automatic fill_tlb(input logic [VPAGE_W-1:0] page, input logic [FNO_W-1:0] f,
                            input logic [TICK_W-1:0] now, output logic [SLOT_W-1:0] s);
        logic found;
        found = 1'b0;
        s = '0;
        for (int j = 0; j < NSLOTS; j++) begin
            if (!found && !tl_valid[j]) begin
                found = 1'b1;
                s = SLOT_W'(j);
            end
        end
        if (found) begin
            if (s == fifo_ptr) fifo_ptr = s + 1'b1;
        end else begin
            s = fifo_ptr;
            fifo_ptr = s + 1'b1;
        end
        // hand the evicted slot's dirty bit back to its frame
        if (tl_valid[s]) begin
            fr_dirty[tl_frame[s]] = tl_dirty[s];
            fr_in_tlb[tl_frame[s]] = 1'b0;
        end
        tl_page[s] = page;
        tl_frame[s] = f;
        tl_valid[s] = 1'b1;
        tl_dirty[s] = fr_dirty[f];
        fr_in_tlb[f] = 1'b1;
        fr_slot[f] = s;
        fr_used[f] = now;
        n_miss = n_miss + 1'b1;
    endtask

    task automatic handle_request(input t_opcode op, input logic [IN_DATA_W-1:0] d,
                                  output t_outcome r);
        logic [VADDR_W-1:0] vaddr;
        logic [PROC_W-1:0]  pid;
        logic [SPACE_W-1:0] space;
        logic               mapped;
        logic [TICK_W-1:0]  now;
        logic [VPAGE_W-1:0] page;
        logic               hit, freef, done;
        int                 f, best;
        logic [TICK_W-1:0]  bestt;
        logic [SLOT_W-1:0]  s;
        vaddr  = d[31:0];
        pid    = d[39:32];
        space  = d[65:40];
        mapped = d[66];
        now    = d[98:67];
        page   = vaddr >> PG_SHIFT;
        r = '0;
        if (op == OP_MARK) begin
            r.status = ST_NO_MATCH;
            done = 1'b0;
            for (int i = 0; i < NSLOTS; i++) begin
                if (!done && tl_valid[i] && tl_page[i] == page) begin
                    done = 1'b1;
                    tl_dirty[i] = 1'b1;
                    r.status = ST_DIRTY;
                    r.frame_no = tl_frame[i];
                    r.slot = SLOT_W'(i);
                end
            end
        end else begin
            hit = 1'b0;
            f = 0;
            for (int i = 0; i < NFRAMES; i++) begin
                if (!hit && fr_valid[i] && fr_page[i] == page && fr_proc[i] == pid) begin
                    hit = 1'b1;
                    f = i;
                end
            end
            if (hit) begin
                r.status = ST_REFILL;
                r.frame_no = FNO_W'(f);
                fill_tlb(page, FNO_W'(f), now, s);
                r.slot = s;
            end else if ({7'd0, page} >= {1'b0, space} && !mapped) begin
                r.status = ST_ADDR_ERR;
            end else begin
                n_fault = n_fault + 1'b1;
                freef = 1'b0;
                best = 0;
                bestt = fr_used[0];
                for (int i = 0; i < NFRAMES; i++) begin
                    if (!freef) begin
                        if (!fr_valid[i]) begin
                            freef = 1'b1;
                            f = i;
                        end else if (fr_used[i] < bestt) begin
                            bestt = fr_used[i];
                            best = i;
                        end
                    end
                end
                if (!freef) f = best;
                if (fr_valid[f]) begin
                    if (fr_in_tlb[f]) begin
                        fr_dirty[f] = tl_dirty[fr_slot[f]];
                        tl_valid[fr_slot[f]] = 1'b0;
                    end
                    r.victim_valid = 1'b1;
                    r.victim_page = fr_page[f];
                    r.victim_proc = fr_proc[f];
                    if (fr_dirty[f]) begin
                        r.wrote_back = 1'b1;
                        n_wb = n_wb + 1'b1;
                    end
                end
                fr_valid[f] = 1'b1;
                fr_proc[f] = pid;
                fr_page[f] = page;
                fr_dirty[f] = 1'b0;
                fr_in_tlb[f] = 1'b0;
                fr_used[f] = '0;
                r.status = ST_FAULT;
                r.frame_no = FNO_W'(f);
                fill_tlb(page, FNO_W'(f), now, s);
                r.slot = s;
            end
        end
        r.misses = n_miss;
        r.faults = n_fault;
        r.writebacks = n_wb;
    endtask

    task automatic check_field(input string name, input longint exp, input longint act);
        if (exp != act) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp, act);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome r, e;
        if (!i_rst_n) begin
            for (int i = 0; i < NFRAMES; i++) begin
                fr_valid[i] = 1'b0;
                fr_in_tlb[i] = 1'b0;
                fr_used[i] = '0;
                fr_dirty[i] = 1'b0;
                fr_slot[i] = '0;
                fr_page[i] = '0;
                fr_proc[i] = '0;
            end
            for (int j = 0; j < NSLOTS; j++) begin
                tl_valid[j] = 1'b0;
                tl_dirty[j] = 1'b0;
                tl_page[j] = '0;
                tl_frame[j] = '0;
            end
            fifo_ptr = '0;
            n_miss = '0;
            n_fault = '0;
            n_wb = '0;
            o_errors = 0;
            outcome_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                handle_request(t_opcode'(i_s_axis_tuser), i_s_axis_tdata, r);
                outcome_q.push_back(r);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, i_m_axis_tuser);
                    o_errors++;
                end else begin
                    e = outcome_q.pop_front();
                    check_field("status", e.status, i_m_axis_tuser);
                    check_field("frame_no", e.frame_no, i_m_axis_tdata[4:0]);
                    check_field("tlb_slot", e.slot, i_m_axis_tdata[6:5]);
                    check_field("victim_valid", e.victim_valid, i_m_axis_tdata[7]);
                    check_field("wrote_back", e.wrote_back, i_m_axis_tdata[8]);
                    check_field("victim_page", e.victim_page, i_m_axis_tdata[33:9]);
                    check_field("victim_proc", e.victim_proc, i_m_axis_tdata[41:34]);
                    check_field("miss_count", e.misses, i_m_axis_tdata[73:42]);
                    check_field("fault_count", e.faults, i_m_axis_tdata[105:74]);
                    check_field("writeback_count", e.writebacks, i_m_axis_tdata[137:106]);
                    check_field("tdata fill", 0, i_m_axis_tdata[OUT_DATA_W-1:138]);
                end
            end
        end
    end

endmodule

### test/tlb_refill_with_lru_frames_test.sv
// Testbench top: drives requests and result back-pressure, gives the verdict.
module tlb_refill_with_lru_frames_test;
    import tlbr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 1430;
    localparam int CALM_TAIL   = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data;
    logic                  s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_DATA_W-1:0] m_data;
    logic [2:0]            m_user;
    int                    errors;
    int                    pending;
    int                    sent;
    logic                  calm;
    logic                  held;
    int                    quiet;

    tlb_refill_with_lru_frames dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    tlb_refill_with_lru_frames_check checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one request and hold it until accepted
    task automatic send_request(input t_opcode op, input logic [24:0] page,
                                input logic [6:0] offs, input logic [7:0] pid,
                                input logic [25:0] space, input logic mapped,
                                input logic [31:0] tick);
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {5'd0, tick, mapped, space, pid, page, offs};
        forever begin
            @(negedge i_clk);
            if (s_ready) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        sent++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // receiver: random stall bursts, one long hold-off, none at the end
    initial begin
        int n;
        m_ready = 1'b0;
        held    = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge i_clk);
            end else if (!held && sent >= 400) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 12);
                m_ready <= ($urandom_range(0, 2) != 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // give up after a long stretch with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [24:0] pages[48];
        logic [31:0] tick;
        logic [24:0] page;
        logic [7:0]  pid;
        logic [25:0] space;
        logic        mapped;
        t_opcode     op;
        int          idle_mode;
        s_valid = 1'b0;
        s_user  = OP_REFILL;
        s_data  = '0;
        i_rst_n = 1'b0;
        sent    = 0;
        calm    = 1'b0;
        tick    = 32'd100;
        idle_mode = 0;
        for (int i = 0; i < 48; i++) pages[i] = (i < 40) ? 25'(i) : 25'($urandom);
        pages[47] = '1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: faults, hits, duplicate TLB entry, marks, address errors, extremes
        send_request(OP_REFILL, 25'd0, 7'd0, 8'd0, 26'd33554432, 1'b0, 32'd10);
        send_request(OP_REFILL, 25'd0, 7'h7f, 8'd0, 26'd1, 1'b0, 32'd11);
        send_request(OP_MARK, 25'd0, 7'd5, 8'd9, 26'd0, 1'b0, 32'd12);
        send_request(OP_MARK, 25'd77, 7'd0, 8'd0, 26'd0, 1'b0, 32'd13);
        send_request(OP_REFILL, 25'd5, 7'd0, 8'd1, 26'd5, 1'b0, 32'd14);
        send_request(OP_REFILL, 25'd5, 7'd0, 8'd1, 26'd5, 1'b1, 32'd15);
        send_request(OP_REFILL, 25'd3, 7'd0, 8'd1, 26'd0, 1'b0, 32'd16);
        send_request(OP_REFILL, '1, 7'h7f, 8'hff, 26'd33554432, 1'b0, 32'hffffffff);
        send_request(OP_REFILL, '1, 7'h7f, 8'hff, 26'd33554431, 1'b0, 32'd17);
        send_request(OP_REFILL, 25'd9, 7'd0, 8'd0, 26'd33554432, 1'b0, 32'd18);
        send_request(OP_MARK, 25'd9, 7'd0, 8'd0, 26'd0, 1'b0, 32'd19);
        send_request(OP_REFILL, 25'd10, 7'd0, 8'd0, 26'd33554432, 1'b0, 32'd20);
        send_request(OP_REFILL, 25'd11, 7'd0, 8'd0, 26'd33554432, 1'b0, 32'd20);
        send_request(OP_REFILL, 25'd9, 7'd0, 8'd0, 26'd33554432, 1'b0, 32'd21);
        send_request(OP_MARK, '1, 7'd0, 8'd0, 26'd0, 1'b0, 32'd0);
        send_request(OP_REFILL, 25'd12, 7'd0, 8'd3, 26'd33554432, 1'b1, 32'd0);
        send_request(OP_REFILL, 25'd13, 7'd0, 8'd3, 26'd33554432, 1'b0, 32'd0);

        for (int k = 0; k < RANDOM_REQS; k++) begin
            if (k % 50 == 0) idle_mode = $urandom_range(0, 2);
            if (k >= RANDOM_REQS - CALM_TAIL) calm = 1'b1;
            // mostly well-formed traffic on a small page and process set
            page   = pages[$urandom_range(0, 47)];
            pid    = 8'($urandom_range(0, 3));
            space  = 26'd33554432;
            mapped = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) pid = 8'($urandom);
            if ($urandom_range(0, 19) == 0) page = 25'($urandom);
            if ($urandom_range(0, 7) == 0) space = 26'($urandom_range(0, 33554432));
            if ($urandom_range(0, 11) == 0) space = 26'($urandom_range(0, 40));
            // advance time, with repeats and jumps to exercise LRU ties
            case ($urandom_range(0, 9))
                0:       tick = $urandom;
                1, 2:    tick = tick;
                default: tick = tick + $urandom_range(1, 5);
            endcase
            op = ($urandom_range(0, 3) == 0) ? OP_MARK : OP_REFILL;
            send_request(op, page, 7'($urandom), pid, space, mapped, tick);
            if (!calm && idle_mode != 0 && $urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 12));
        end
        s_valid <= 1'b0;
        calm = 1'b1;

        // let the checker register the last request before draining
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
